### hdl/shpd_pkg.sv
// ----------------------------------------------------------------------------
// shpd_pkg
// Shared types and constants for the sync header packet deframer.
// ----------------------------------------------------------------------------
package shpd_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [8:0] SYNC_LEN      = 9'd4;
    localparam logic [8:0] PAYLOAD_START = 9'd8;

    // one result item as it travels from the parser to the output register
    typedef struct packed {
        logic [7:0] byte_index;
        logic [7:0] data_byte;
        logic       packet_end;
        logic       checksum_ok;
    } t_result;

endpackage

### hdl/shpd_in_if.sv
// ----------------------------------------------------------------------------
// shpd_in_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface shpd_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

### hdl/shpd_out_if.sv
// ----------------------------------------------------------------------------
// shpd_out_if
// Captured byte channel: valid/ready handshake with index, byte and flags.
// ----------------------------------------------------------------------------
interface shpd_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic       packet_end;
    logic       checksum_ok;

    modport source (
        output valid, output byte_index, output data_byte,
        output packet_end, output checksum_ok, input ready
    );
    modport sink (
        input valid, input byte_index, input data_byte,
        input packet_end, input checksum_ok, output ready
    );

endinterface

### hdl/shpd_parser.sv
// ----------------------------------------------------------------------------
// shpd_parser
// Header hunt, control byte capture and payload sum; one byte per transfer.
// ----------------------------------------------------------------------------
module shpd_parser
    import shpd_pkg::*;
#(
    parameter int PACKET_BYTES = 136,
    parameter int CHECK_OFFSET = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_result    o_result
);

    localparam logic [8:0] PktLen   = 9'(PACKET_BYTES);
    localparam logic [8:0] CheckIdx = 9'(CHECK_OFFSET);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CTRL = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [8:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_check, n_check;

    logic [8:0] count_inc;
    logic [7:0] sum_inc;

    assign count_inc = r_count + 9'd1;
    assign sum_inc   = r_sum + i_byte;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        n_check  = r_check;
        o_emit   = 1'b0;
        o_result = '{byte_index: r_count[7:0], data_byte: i_byte,
                     packet_end: 1'b0, checksum_ok: 1'b0};
        case (r_phase)
            PH_CTRL: begin
                o_emit = 1'b1;
                if (r_count == CheckIdx) begin
                    n_check = i_byte;
                end
                n_count = count_inc;
                if (count_inc >= PAYLOAD_START) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                o_emit = 1'b1;
                if (count_inc >= PktLen) begin
                    o_result.packet_end  = 1'b1;
                    o_result.checksum_ok = (sum_inc == r_check);
                    n_phase = PH_HUNT;
                    n_count = '0;
                    n_sum   = '0;
                end else begin
                    n_count = count_inc;
                    n_sum   = sum_inc;
                end
            end
            PH_HUNT: begin
                if (i_byte == SYNC_BYTE) begin
                    if (count_inc >= SYNC_LEN) begin
                        n_count = SYNC_LEN;
                        n_phase = PH_CTRL;
                    end else begin
                        n_count = count_inc;
                    end
                end else begin
                    n_count = '0;
                end
            end
            default: begin
                // unreachable phase code: hunt again, restarting the run with the current byte
                n_phase = PH_HUNT;
                n_count = (i_byte == SYNC_BYTE) ? 9'd1 : 9'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_sum   <= '0;
            r_check <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_check <= n_check;
        end
    end

endmodule

### hdl/shpd_out_reg.sv
// ----------------------------------------------------------------------------
// shpd_out_reg
// Result register with valid/ready; loads while empty or being drained.
// ----------------------------------------------------------------------------
module shpd_out_reg
    import shpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_emit,
    input  t_result i_result,
    output logic    o_space,
    shpd_out_if.source o_res
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.byte_index  = r_result.byte_index;
    assign o_res.data_byte   = r_result.data_byte;
    assign o_res.packet_end  = r_result.packet_end;
    assign o_res.checksum_ok = r_result.checksum_ok;

endmodule

### hdl/sync_header_packet_deframer.sv
// output: a captured byte is registered once and appears on o_res in the cycle after its input transfer
// throughput: one byte per cycle while o_res is drained; the single result
//   register back-pressures i_rx when it is full and not being taken
// bytes taken while hunting produce no result; control and payload bytes one each
// reset: synchronous active-low i_rst_n returns to header hunt, empties the
//   result register and clears count, sum and kept checksum
// ----------------------------------------------------------------------------
// sync_header_packet_deframer
// Finds a four byte 0xFF header and emits the following packet bytes with
// their index, flagging the last one with the additive checksum result.
// ----------------------------------------------------------------------------
module sync_header_packet_deframer
    import shpd_pkg::*;
#(
    parameter int PACKET_BYTES = 136,
    parameter int CHECK_OFFSET = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    shpd_in_if.sink    i_rx,
    shpd_out_if.source o_res
);

    logic    space;
    logic    take;
    logic    emit;
    t_result result;

    assign i_rx.ready = space;
    assign take       = i_rx.valid && space;

    shpd_parser #(
        .PACKET_BYTES (PACKET_BYTES),
        .CHECK_OFFSET (CHECK_OFFSET)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_rx.rx_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    shpd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_emit   (emit),
        .i_result (result),
        .o_space  (space),
        .o_res    (o_res)
    );

endmodule

### hdl/shpd_checker.sv
// ----------------------------------------------------------------------------
// shpd_checker
// Port-level checks on the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module shpd_checker #(
    parameter int PACKET_BYTES = 136
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_byte_index,
    input logic       i_packet_end,
    input logic       i_checksum_ok
);

    localparam logic [7:0] LastIdx = 8'(PACKET_BYTES - 1);

    // a stalled result stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // nothing comes out right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // checksum flag only on the last byte of a packet
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_checksum_ok |-> i_packet_end)
        else $error("checksum flag without packet end");

    // header positions are never emitted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_byte_index >= 8'd4)
        else $error("byte index inside header");

    // the packet ends exactly at its last position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_packet_end == (i_byte_index == LastIdx)))
        else $error("packet end at wrong index");

endmodule

bind sync_header_packet_deframer shpd_checker #(
    .PACKET_BYTES (PACKET_BYTES)
) u_shpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_byte_index  (o_res.byte_index),
    .i_packet_end  (o_res.packet_end),
    .i_checksum_ok (o_res.checksum_ok)
);
